// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the LED strip frame writer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lsfw_pkg.sv -----
// Shared types, constants and helpers for the LED strip frame writer.
// No dependencies; used by lsfw_cell, led_strip_frame_writer_top, frame_word_checker and tb.
package lsfw_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int MASK_BITS     = 8;
    localparam int COLOUR_W      = 24;
    localparam int WORD_W        = 32;

    localparam logic [7:0]        LED_PREFIX = 8'hFF;
    localparam logic [WORD_W-1:0] START_WORD = '0;
    localparam logic [WORD_W-1:0] END_WORD   = '1;

    localparam logic CMD_SET     = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] led_select;
        logic       no_refresh;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] frame_word;
        logic              last_word;
    } out_item_t;

    // Stored colour is {red, green, blue}; the wire order is prefix, blue, green, red.
    function automatic logic [WORD_W-1:0] make_led_word(input logic [COLOUR_W-1:0] colour);
        make_led_word = {LED_PREFIX, colour[7:0], colour[15:8], colour[23:16]};
    endfunction

endpackage

// ----- src/lsfw_cell.sv -----
// One LED cell: holds a 24-bit colour and hands it to its neighbor on a shift.
// Depends on lsfw_pkg for the colour width.
module lsfw_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               write_en,
    input  logic [lsfw_pkg::COLOUR_W-1:0]      write_colour,
    input  logic                               shift_en,
    input  logic [lsfw_pkg::COLOUR_W-1:0]      neighbor_colour,
    output logic [lsfw_pkg::COLOUR_W-1:0]      colour
);

    logic [lsfw_pkg::COLOUR_W-1:0] colour_reg;
    logic [lsfw_pkg::COLOUR_W-1:0] colour_next;

    always_comb
    begin
        colour_next = colour_reg;
        if (write_en)
        begin
            colour_next = write_colour;
        end
        else if (shift_en)
        begin
            colour_next = neighbor_colour;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= '0;
        end
        else
        begin
            colour_reg <= colour_next;
        end
    end

    assign colour = colour_reg;

endmodule

// ----- src/led_strip_frame_writer_top.sv -----
// Top level of the LED strip frame writer: command intake, cell ring and frame sequencer.
// Depends on lsfw_pkg, lsfw_cell and assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_data  (lsfw_pkg::in_item_t)
//  out     | output    | out_valid / out_ready  | out_data (lsfw_pkg::out_item_t)
//
// A command is taken only while the sequencer is idle; a frame then leaves as LED_COUNT + 2
// beats, one per cycle while out_ready stays high. The cell ring rotates one colour toward
// cell 0 for each LED word. A set without refresh sends no frame. Reset clears every colour
// and the sequencer. A stalled output beat holds the sequencer and the ring in place.
module led_strip_frame_writer_top #(
    parameter int LED_COUNT = lsfw_pkg::LED_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lsfw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lsfw_pkg::out_item_t out_data
);

    localparam int CNT_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_LEDS,
        ST_END
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    lsfw_pkg::out_item_t out_data_reg;
    lsfw_pkg::out_item_t out_data_next;

    logic in_accept;
    logic word_load;
    logic set_write;
    logic ring_shift;

    logic [lsfw_pkg::COLOUR_W-1:0] write_colour;
    logic [lsfw_pkg::COLOUR_W-1:0] cell_colour [LED_COUNT];

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign set_write  = in_accept && (in_data.command == lsfw_pkg::CMD_SET);
    assign word_load  = (state_reg != ST_IDLE) && (!out_valid_reg || out_ready);
    assign ring_shift = word_load && (state_reg == ST_LEDS);

    assign write_colour = {in_data.red, in_data.green, in_data.blue};

    // Cell n takes its colour from cell n+1; the last cell closes the ring from cell 0,
    // so after LED_COUNT shifts every colour is back in its own cell.
    for (genvar i = 0; i < LED_COUNT; i++)
    begin : g_cell
        logic sel;

        if (i < lsfw_pkg::MASK_BITS)
        begin : g_mask
            assign sel = in_data.led_select[i];
        end
        else
        begin : g_nomask
            assign sel = 1'b0;
        end

        lsfw_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .write_en        (set_write && sel),
            .write_colour    (write_colour),
            .shift_en        (ring_shift),
            .neighbor_colour (cell_colour[(i + 1) % LED_COUNT]),
            .colour          (cell_colour[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept &&
                    ((in_data.command == lsfw_pkg::CMD_REFRESH) || !in_data.no_refresh))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (word_load)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.frame_word = lsfw_pkg::START_WORD;
                    out_data_next.last_word  = 1'b0;
                    cnt_next                 = '0;
                    state_next               = ST_LEDS;
                end
            end
            ST_LEDS:
            begin
                if (word_load)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.frame_word = lsfw_pkg::make_led_word(cell_colour[0]);
                    out_data_next.last_word  = 1'b0;
                    cnt_next                 = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(LED_COUNT - 1))
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (word_load)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.frame_word = lsfw_pkg::END_WORD;
                    out_data_next.last_word  = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`include "assert_macros.svh"

    `ASSERT_SAME(a_cnt_range, state_reg == ST_LEDS, cnt_reg <= CNT_W'(LED_COUNT - 1),
                 "LED counter out of range")
    `ASSERT_NEXT(a_end_marked, word_load && state_reg == ST_END,
                 out_valid && out_data.last_word, "end word not marked last")
    `ASSERT_NEXT(a_frame_start, in_accept && in_data.command == lsfw_pkg::CMD_REFRESH,
                 state_reg == ST_START, "refresh did not start a frame")

endmodule

// ----- verif/frame_word_checker.sv -----
// Scoreboard for the LED strip frame writer: watches both channels and predicts each frame.
// Keeps its own copy of the colour store; depends on lsfw_pkg only.
`timescale 1ns / 100ps

module frame_word_checker #(
    parameter int LED_COUNT = lsfw_pkg::LED_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  lsfw_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  lsfw_pkg::out_item_t out_data,
    output int                  mismatches,
    output int                  words_pending,
    output int                  words_checked
);

    logic [lsfw_pkg::COLOUR_W-1:0] led_colour [LED_COUNT];
    lsfw_pkg::out_item_t           expected_words [$];

    task automatic queue_frame();
        lsfw_pkg::out_item_t w;
        w.frame_word = lsfw_pkg::START_WORD;
        w.last_word  = 1'b0;
        expected_words.push_back(w);
        // Colours are held as {red, green, blue} but leave as prefix, blue, green, red.
        for (int n = 0; n < LED_COUNT; n++)
        begin
            w.frame_word = {lsfw_pkg::LED_PREFIX, led_colour[n][7:0], led_colour[n][15:8],
                            led_colour[n][23:16]};
            expected_words.push_back(w);
        end
        w.frame_word = lsfw_pkg::END_WORD;
        w.last_word  = 1'b1;
        expected_words.push_back(w);
    endtask

    task automatic apply_command(input lsfw_pkg::in_item_t cmd);
        if (cmd.command == lsfw_pkg::CMD_REFRESH)
        begin
            queue_frame();
            return;
        end
        for (int n = 0; n < LED_COUNT && n < lsfw_pkg::MASK_BITS; n++)
        begin
            if (cmd.led_select[n])
                led_colour[n] = {cmd.red, cmd.green, cmd.blue};
        end
        if (!cmd.no_refresh)
            queue_frame();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lsfw_pkg::out_item_t exp_w;
        int                  errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int n = 0; n < LED_COUNT; n++)
                led_colour[n] = '0;
            expected_words.delete();
            mismatches    <= 0;
            words_pending <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_command(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got word %h last %b",
                             $time, out_data.frame_word, out_data.last_word);
                    errs++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_data.frame_word !== exp_w.frame_word)
                    begin
                        $display("%0t: frame_word expected %h, got %h",
                                 $time, exp_w.frame_word, out_data.frame_word);
                        errs++;
                    end
                    if (out_data.last_word !== exp_w.last_word)
                    begin
                        $display("%0t: last_word expected %b, got %b",
                                 $time, exp_w.last_word, out_data.last_word);
                        errs++;
                    end
                end
                words_checked <= words_checked + 1;
            end
            mismatches    <= mismatches + errs;
            words_pending <= expected_words.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the LED strip frame writer: clock, reset, command stimulus and verdict.
// Depends on lsfw_pkg, led_strip_frame_writer_top and frame_word_checker.
`timescale 1ns / 100ps

module tb;

    localparam int RANDOM_ITEMS = 420;
    localparam int TAIL_ITEMS   = 60;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lsfw_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_ready;
    lsfw_pkg::out_item_t out_data;

    int mismatches;
    int words_pending;
    int words_checked;

    bit tail_phase;
    bit long_hold_req;
    bit long_hold_done;

    int n_refresh;
    int n_set_frame;
    int n_set_quiet;
    int unsigned cycles;

    led_strip_frame_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    frame_word_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    initial
        clk = 1'b0;

    always #10 clk = ~clk;

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d words outstanding",
                         cycles, words_pending);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic lsfw_pkg::in_item_t make_command(input logic cmd,
                                                        input logic [7:0] mask,
                                                        input logic nr,
                                                        input logic [7:0] r,
                                                        input logic [7:0] g,
                                                        input logic [7:0] b);
        lsfw_pkg::in_item_t c;
        c.command    = cmd;
        c.led_select = mask;
        c.no_refresh = nr;
        c.red        = r;
        c.green      = g;
        c.blue       = b;
        return c;
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic lsfw_pkg::in_item_t random_command();
        lsfw_pkg::in_item_t c;
        c.command = ($urandom_range(0, 3) == 0) ? lsfw_pkg::CMD_REFRESH : lsfw_pkg::CMD_SET;
        case ($urandom_range(0, 7))
            0:       c.led_select = 8'h00;
            1:       c.led_select = 8'hFF;
            2, 3:    c.led_select = 8'h01 << $urandom_range(0, 7);
            default: c.led_select = 8'($urandom);
        endcase
        c.no_refresh = ($urandom_range(0, 2) == 0);
        c.red        = random_level();
        c.green      = random_level();
        c.blue       = random_level();
        return c;
    endfunction

    // Offers one command and returns in the cycle it is taken, with valid still high.
    task automatic send_command(input lsfw_pkg::in_item_t cmd);
        if (!tail_phase && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (cmd.command == lsfw_pkg::CMD_REFRESH)
            n_refresh++;
        else if (cmd.no_refresh)
            n_set_quiet++;
        else
            n_set_frame++;
    endtask

    // Output side: random stalls, plus one long hold-off while the sender keeps going.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: cleared store, extremes, empty mask, quiet sets, ignored fields.
        send_command(make_command(lsfw_pkg::CMD_REFRESH, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'hFF, 1'b0, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h00, 1'b0, 8'h12, 8'h34, 8'h56));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h01, 1'b1, 8'hFF, 8'h00, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h02, 1'b1, 8'h00, 8'hFF, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h04, 1'b1, 8'h00, 8'h00, 8'hFF));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h80, 1'b1, 8'hA5, 8'h5A, 8'hC3));
        send_command(make_command(lsfw_pkg::CMD_REFRESH, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h00, 1'b1, 8'h77, 8'h88, 8'h99));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h55, 1'b0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'hAA, 1'b0, 8'h80, 8'h01, 8'h7F));
        send_command(make_command(lsfw_pkg::CMD_REFRESH, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'h18, 1'b0, 8'h01, 8'h80, 8'hFE));
        send_command(make_command(lsfw_pkg::CMD_SET,     8'hFF, 1'b1, 8'h00, 8'h00, 8'h00));
        send_command(make_command(lsfw_pkg::CMD_REFRESH, 8'h5A, 1'b1, 8'h3C, 8'hC3, 8'h0F));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 150)
                long_hold_req = 1'b1;
            if (i == 300)
            begin
                // Let the output side empty completely before going on.
                in_valid <= 1'b0;
                @(posedge clk);
                while (words_pending != 0)
                    @(posedge clk);
            end
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            send_command(random_command());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d refreshes, %0d sets with a frame and %0d quiet sets;",
                 n_refresh, n_set_frame, n_set_quiet);
        $display("checked %0d frame words, through a long output stall and a full drain.",
                 words_checked);
        if (mismatches == 0 && words_pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
